[hdl/nfv_pkg.sv]
package nfv_pkg;

   localparam int SLOT_BITS = 16;
   localparam int MAG_BITS  = 64;

   typedef enum logic [1:0] {
      MODE_FLOAT = 2'd0,
      MODE_U16   = 2'd1,
      MODE_U64   = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FM_FLOAT = 2'd0,
      FM_U16   = 2'd1,
      FM_U64   = 2'd2
   } fmode_type;

   typedef enum logic [2:0] {
      CC_SPACE,
      CC_DIGIT,
      CC_SIGN,
      CC_EXP,
      CC_POINT,
      CC_OTHER
   } char_class_type;

   typedef enum logic [3:0] {
      PH_START    = 4'd0,
      PH_SIGN     = 4'd1,
      PH_INT      = 4'd2,
      PH_LPOINT   = 4'd3,
      PH_FRAC     = 4'd4,
      PH_EXP      = 4'd5,
      PH_ESIGN    = 4'd6,
      PH_EDIG     = 4'd7,
      PH_TRAIL    = 4'd8,
      PH_TRAIL_ND = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADNUM   = 3'd2,
      ST_BADEXP   = 3'd3,
      ST_BADCHAR  = 3'd4,
      ST_BADFIELD = 3'd5,
      ST_RANGE    = 3'd6,
      ST_NODIG    = 3'd7
   } status_type;

   typedef struct packed {
      char_class_type cls;
      logic           minus;
      logic [3:0]     digit;
      logic           last;
      logic           empty;
   } token_type;

   typedef struct packed {
      status_type            err;
      phase_type             phase;
      logic [MAG_BITS-1:0]   mag;
      logic                  neg;
      logic                  ovf;
      fmode_type             fmode;
   } finish_type;

   function automatic fmode_type mode_to_fmode(input logic [1:0] mode);
      fmode_type f;
      unique case (mode)
         MODE_FLOAT: f = FM_FLOAT;
         MODE_U16:   f = FM_U16;
         default:    f = FM_U64;
      endcase
      return f;
   endfunction

endpackage

[hdl/nfv_front.sv]
module nfv_front (
   input  logic [7:0]         ch,
   input  logic               last,
   input  logic               empty_field,
   output nfv_pkg::token_type token
);
   import nfv_pkg::*;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;

   logic [7:0] offset;

   always_comb begin
      offset = ch - CH_ZERO;
      token.minus = (ch == CH_MINUS);
      token.digit = offset[3:0];
      token.last  = last;
      token.empty = empty_field;
      priority if (ch == CH_SPACE || ch == CH_TAB) begin
         token.cls = CC_SPACE;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         token.cls = CC_DIGIT;
      end else if (ch == CH_PLUS || ch == CH_MINUS) begin
         token.cls = CC_SIGN;
      end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
         token.cls = CC_EXP;
      end else if (ch == CH_POINT) begin
         token.cls = CC_POINT;
      end else begin
         token.cls = CC_OTHER;
      end
   end

endmodule

[hdl/nfv_queue.sv]
module nfv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  nfv_pkg::token_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output nfv_pkg::token_type rd_data
);
   import nfv_pkg::*;

   token_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      wr_ready  = (count_ff != 2'd2);
      rd_valid  = (count_ff != 2'd0);
      rd_data   = mem[rd_ptr_ff];
      push      = wr_valid && wr_ready;
      pop       = rd_valid && rd_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/nfv_back.sv]
module nfv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          mode,
   input  logic                tok_valid,
   output logic                tok_ready,
   input  nfv_pkg::token_type  tok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nfv_pkg::status_type rsp_status,
   output logic [63:0]         rsp_value,
   output logic [15:0]         rsp_slot
);
   import nfv_pkg::*;

   localparam int ACC_BITS = MAG_BITS + 4;

   // field state
   phase_type             phase_ff, phase_in;
   status_type            err_ff, err_in;
   logic [MAG_BITS-1:0]   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  ovf_ff, ovf_in;
   logic                  started_ff;
   fmode_type             fmode_ff, fmode_cur;

   // finishing stage
   logic                  done_valid_ff;
   finish_type            done_ff, done_in;
   logic                  done_ready;

   // result register
   logic                  rsp_valid_ff;
   status_type            status_ff, status_in;
   logic [MAG_BITS-1:0]   value_ff, value_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SLOT_BITS-1:0]  next_slot_ff, next_slot_in;
   logic                  rsp_load;

   logic                  sp, dg, sg, ex, pt;
   logic                  add_dig;
   logic [ACC_BITS-1:0]   acc;
   logic                  end_item, fire;
   status_type            pre_status;
   logic [MAG_BITS-1:0]   signed_val;

   always_comb begin
      rsp_load   = done_valid_ff && (!rsp_valid_ff || rsp_ready);
      done_ready = !done_valid_ff || rsp_load;
      end_item   = tok.last || tok.empty;
      fire       = tok_valid && (!end_item || done_ready);
      tok_ready  = !end_item || done_ready;
      fmode_cur  = started_ff ? fmode_ff : mode_to_fmode(mode);

      sp = (tok.cls == CC_SPACE);
      dg = (tok.cls == CC_DIGIT);
      sg = (tok.cls == CC_SIGN);
      ex = (tok.cls == CC_EXP);
      pt = (tok.cls == CC_POINT);

      phase_in = phase_ff;
      err_in   = err_ff;
      neg_in   = neg_ff;
      add_dig  = 1'b0;

      if (!tok.empty && err_ff == ST_OK) begin
         if (fmode_cur == FM_FLOAT) begin
            unique case (phase_ff)
               PH_START: begin
                  priority if (sp) phase_in = PH_START;
                  else if (sg) phase_in = PH_SIGN;
                  else if (dg) phase_in = PH_INT;
                  else if (pt) phase_in = PH_LPOINT;
                  else err_in = ST_BADCHAR;
               end
               PH_SIGN: begin
                  priority if (dg) phase_in = PH_INT;
                  else if (pt) phase_in = PH_LPOINT;
                  else err_in = ST_BADCHAR;
               end
               PH_INT, PH_FRAC: begin
                  priority if (dg) phase_in = phase_ff;
                  else if (pt && phase_ff == PH_INT) phase_in = PH_FRAC;
                  else if (ex) phase_in = PH_EXP;
                  else if (sp) phase_in = PH_TRAIL;
                  else err_in = ST_BADCHAR;
               end
               PH_LPOINT: begin
                  if (dg) phase_in = PH_FRAC;
                  else err_in = ST_BADFIELD;
               end
               PH_EXP: begin
                  priority if (sg) phase_in = PH_ESIGN;
                  else if (dg) phase_in = PH_EDIG;
                  else err_in = ST_BADEXP;
               end
               PH_ESIGN: begin
                  if (dg) phase_in = PH_EDIG;
                  else err_in = ST_BADEXP;
               end
               PH_EDIG: begin
                  priority if (dg) phase_in = PH_EDIG;
                  else if (sp) phase_in = PH_TRAIL;
                  else err_in = ST_BADCHAR;
               end
               default: begin
                  if (!sp) err_in = ST_BADCHAR;
               end
            endcase
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  priority if (sp) begin
                     phase_in = PH_START;
                  end else if (sg) begin
                     phase_in = PH_SIGN;
                     neg_in   = tok.minus;
                  end else if (dg) begin
                     phase_in = PH_INT;
                     add_dig  = 1'b1;
                  end else begin
                     err_in = ST_BADCHAR;
                  end
               end
               PH_SIGN: begin
                  priority if (dg) begin
                     phase_in = PH_INT;
                     add_dig  = 1'b1;
                  end else if (sp) begin
                     phase_in = PH_TRAIL_ND;
                  end else begin
                     err_in = ST_BADCHAR;
                  end
               end
               PH_INT: begin
                  priority if (dg) add_dig = 1'b1;
                  else if (sp) phase_in = PH_TRAIL;
                  else err_in = ST_BADCHAR;
               end
               default: begin
                  if (!sp) err_in = ST_BADCHAR;
               end
            endcase
         end
      end

      // times ten plus digit, saturating
      acc = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + ACC_BITS'(tok.digit);
      mag_in = mag_ff;
      ovf_in = ovf_ff;
      if (add_dig) begin
         if (acc[ACC_BITS-1:MAG_BITS] != 4'd0) begin
            ovf_in = 1'b1;
            mag_in = '1;
         end else begin
            mag_in = acc[MAG_BITS-1:0];
         end
      end

      done_in.err   = err_in;
      done_in.phase = phase_in;
      done_in.mag   = mag_in;
      done_in.neg   = neg_in;
      done_in.ovf   = ovf_in;
      done_in.fmode = fmode_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         err_ff     <= ST_OK;
         mag_ff     <= '0;
         neg_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         started_ff <= 1'b0;
         fmode_ff   <= FM_FLOAT;
      end else if (fire) begin
         if (end_item) begin
            phase_ff   <= PH_START;
            err_ff     <= ST_OK;
            mag_ff     <= '0;
            neg_ff     <= 1'b0;
            ovf_ff     <= 1'b0;
            started_ff <= 1'b0;
         end else begin
            phase_ff   <= phase_in;
            err_ff     <= err_in;
            mag_ff     <= mag_in;
            neg_ff     <= neg_in;
            ovf_ff     <= ovf_in;
            started_ff <= 1'b1;
            fmode_ff   <= fmode_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_valid_ff <= 1'b0;
      end else if (fire && end_item) begin
         done_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         done_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && end_item) begin
         done_ff <= done_in;
      end
   end

   // end of field judgement
   always_comb begin
      if (done_ff.err != ST_OK) begin
         pre_status = done_ff.err;
      end else begin
         unique case (done_ff.phase)
            PH_START:           pre_status = ST_EMPTY;
            PH_SIGN, PH_LPOINT: pre_status = ST_BADNUM;
            PH_EXP, PH_ESIGN:   pre_status = ST_BADEXP;
            PH_TRAIL_ND:        pre_status = ST_NODIG;
            default:            pre_status = ST_OK;
         endcase
      end
      signed_val = done_ff.neg ? (MAG_BITS'(0) - done_ff.mag) : done_ff.mag;
      status_in  = pre_status;
      value_in   = '0;
      if (pre_status == ST_OK && done_ff.fmode != FM_FLOAT) begin
         if (done_ff.ovf ||
             (done_ff.fmode == FM_U16 && signed_val[MAG_BITS-1:16] != '0)) begin
            status_in = ST_RANGE;
         end else begin
            value_in = signed_val;
         end
      end
      slot_in      = (status_in == ST_OK) ? next_slot_ff : '0;
      next_slot_in = (status_in == ST_OK) ? next_slot_ff + SLOT_BITS'(1) : next_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         next_slot_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            next_slot_ff <= next_slot_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         slot_ff   <= slot_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_slot   = 16'(slot_ff);

endmodule

[hdl/numeric_field_validator.sv]
// numeric_field_validator
// Checks text fields for decimal number syntax, one character per request.
// req channel: tdata[7:0] is the character, tlast marks the last character
// of a field, tuser[0] marks an empty field (ends the field, character unused).
// rsp channel: one response per field with status, value and slot.
// csr_wr_en/csr_wr_data write the mode (0 float syntax, 1 u16, 2 u64); the
// mode is sampled at the first character of a field.
// Throughput is one character per cycle unless a field end must wait for
// the finishing stage: a character classifier feeds a two-entry queue, and
// the parser with its times-ten accumulator consumes one queued character per cycle.
// The last character of a field passes the queue and the parser into the
// finishing stage, then the range check into the result register behind rsp_tvalid.
// While the receiver stalls, one result waits in the output register and one
// in the finishing stage; characters that do not end a field keep flowing
// until the queue fills, after which req_tready drops.
// Reset clears the mode to float, the parser state and the slot counter.
module numeric_field_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   input  logic [0:0]  req_tuser,   // [0] empty_field
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [2:0] status, [66:3] value, [82:67] slot, zero pad
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import nfv_pkg::*;

   logic [1:0] mode_ff;
   token_type  tok_in, tok_q;
   logic       q_valid, q_ready;
   status_type rsp_status;
   logic [63:0] rsp_value;
   logic [15:0] rsp_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FLOAT;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   nfv_front u_front (
      .ch          (req_tdata),
      .last        (req_tlast),
      .empty_field (req_tuser[0]),
      .token       (tok_in)
   );

   nfv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (tok_in),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (tok_q)
   );

   nfv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .tok_valid  (q_valid),
      .tok_ready  (q_ready),
      .tok        (tok_q),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_slot   (rsp_slot)
   );

   assign rsp_tdata = {5'b0, rsp_slot, rsp_value, rsp_status};

endmodule
